FILE: design/wspc_pkg.sv
// ----------------------------------------------------------------------------
// wspc_pkg
// Shared constants and helper types for the wheel speed PID controller.
// ----------------------------------------------------------------------------
package wspc_pkg;

  // Width of the unsigned serial dividend and divisor.
  localparam int DivW = 64;
  // Width of the quotient counter index.
  localparam int DivCntW = 7;

  // Configuration register indexes.
  localparam logic [2:0] RegTarget   = 3'd0;
  localparam logic [2:0] RegScale    = 3'd1;
  localparam logic [2:0] RegOverall  = 3'd2;
  localparam logic [2:0] RegIntegral = 3'd3;
  localparam logic [2:0] RegRate     = 3'd4;

  // Command to the serial divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/wspc_div.sv
// ----------------------------------------------------------------------------
// wspc_div
// Restoring unsigned divider, one quotient bit per cycle.
// A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module wspc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wspc_pkg::div_req_t            req,
  output logic                          done,
  output logic [wspc_pkg::DivW-1:0]     quot
);

  logic [wspc_pkg::DivW-1:0]    rem_r, rem_nxt;
  logic [wspc_pkg::DivW-1:0]    q_r, q_nxt;
  logic [wspc_pkg::DivW-1:0]    d_r, d_nxt;
  logic [wspc_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [wspc_pkg::DivW:0]      trial;
  logic [wspc_pkg::DivW-1:0]    rem_sh;

  // One shift-subtract step a cycle
  always_comb begin
    rem_sh   = {rem_r[wspc_pkg::DivW-2:0], q_r[wspc_pkg::DivW-1]};
    trial    = {1'b0, rem_sh} - {1'b0, d_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      d_nxt    = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[wspc_pkg::DivW]) begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[wspc_pkg::DivW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[wspc_pkg::DivW-1:0];
        q_nxt   = {q_r[wspc_pkg::DivW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == wspc_pkg::DivCntW'(wspc_pkg::DivW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Zero divisor: all-ones quotient from restoring division is forced to 0
  assign done = done_r;
  assign quot = (d_r == '0) ? '0 : q_r;

endmodule

FILE: design/wheel_speed_pid_controller_unit.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_unit
// Encoder pulse counter and fixed-point PID step for one wheel.
// ----------------------------------------------------------------------------
// Usage:
//   in_kind=0 items are encoder pulses: counted, no result.
//   in_kind=1 items are control ticks carrying in_now_us; each gives one
//   result (measured velocity, control value, saturation flag).
//   A tick runs three divisions on one shared 64-step serial divider
//   (velocity, rate, integral), each with a start state and a done state,
//   plus states for multiply and clip, before out_valid is raised.
//   One tick is in work at a time; in_ready is low while a tick is processed.
//   The result sits in an output register until out_ready. While it waits,
//   pulses and the next tick are still taken; a tick that finishes while
//   the previous result is stalled holds in its last step, with in_ready
//   low, until that result leaves.
//   Configuration writes on cfg_we are applied at once; write only when
//   idle. Out-of-range indexes are ignored.
//   Reset (rst_n low, synchronous) clears the state, pulse count, timestamps,
//   last error, sums, target, scale, out_valid; gain defaults 3, 2 and 1.
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_measured_velocity,
  output logic signed [31:0] out_control_value,
  output logic        out_saturated
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StVel    = 4'd1;
  localparam logic [3:0] StVelW   = 4'd2;
  localparam logic [3:0] StErr    = 4'd3;
  localparam logic [3:0] StRateW  = 4'd4;
  localparam logic [3:0] StAcc    = 4'd5;
  localparam logic [3:0] StIntM   = 4'd6;
  localparam logic [3:0] StIntW   = 4'd7;
  localparam logic [3:0] StSum    = 4'd8;
  localparam logic [3:0] StMul    = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;
  localparam logic signed [47:0] Max48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Min48 = 48'sh8000_0000_0000;

  logic [3:0]  st_r;
  logic [31:0] target_r, scale_r;
  logic [7:0]  kp_r, ki_r, kd_r;
  logic [31:0] pcnt_r, chk_r, prevt_r, span_r, delta_r;
  logic signed [31:0] perr_r, err_r, rate_r, integ_r;
  logic signed [47:0] esum_r;
  logic [47:0] tsum_r;
  logic signed [63:0] prod_r, total_r;
  logic [30:0] meas_r;
  logic        sat_r, neg_r;
  logic [30:0] o_meas_r;
  logic signed [31:0] o_ctl_r;
  logic        o_sat_r, o_valid_r;

  wspc_pkg::div_req_t        dreq;
  logic                      ddone;
  logic [wspc_pkg::DivW-1:0] dq;

  wspc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  // Helper values
  logic signed [63:0] err_w, diff_w, sum_w, qs_w;
  logic signed [48:0] esum_w;
  logic [48:0]        tsum_w;
  logic [63:0]        mag_w;
  always_comb begin
    err_w  = 64'(signed'(target_r)) - 64'(signed'({1'b0, meas_r}));
    diff_w = 64'(perr_r) - 64'(err_r);
    esum_w = 49'(esum_r) + 49'(err_r);
    tsum_w = {1'b0, tsum_r} + {17'd0, delta_r};
    qs_w   = neg_r ? -signed'(dq) : signed'(dq);
    sum_w  = 64'(err_r) + 64'(integ_r) + prod_r;
    mag_w  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    case (st_r)
      StVel: begin
        dreq.start = 1'b1; dreq.dividend = prod_r; dreq.divisor = {32'd0, span_r};
      end
      StErr: begin
        dreq.start = 1'b1; dreq.dividend = mag_w; dreq.divisor = {32'd0, delta_r};
      end
      StIntM: begin
        dreq.start = 1'b1; dreq.dividend = mag_w; dreq.divisor = {16'd0, tsum_r};
      end
      default: ;
    endcase
  end

  assign in_ready = (st_r == StIdle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; target_r <= '0; scale_r <= '0;
      kp_r <= 8'd3; ki_r <= 8'd2; kd_r <= 8'd1;
      pcnt_r <= '0; chk_r <= '0; prevt_r <= '0; perr_r <= '0;
      esum_r <= '0; tsum_r <= '0; o_valid_r <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          wspc_pkg::RegTarget:   target_r <= cfg_data;
          wspc_pkg::RegScale:    scale_r  <= cfg_data;
          wspc_pkg::RegOverall:  kp_r     <= cfg_data[7:0];
          wspc_pkg::RegIntegral: ki_r     <= cfg_data[7:0];
          wspc_pkg::RegRate:     kd_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (o_valid_r && out_ready) o_valid_r <= 1'b0;
      case (st_r)
        StIdle: if (in_valid && in_ready) begin
          if (!in_kind) begin
            if (pcnt_r != 32'hFFFF_FFFF) pcnt_r <= pcnt_r + 1'b1;
          end else begin
            span_r  <= in_now_us - chk_r;
            delta_r <= in_now_us - prevt_r;
            chk_r   <= in_now_us;
            prevt_r <= in_now_us;
            prod_r  <= 64'(pcnt_r) * 64'(scale_r);
            pcnt_r  <= '0;
            sat_r   <= 1'b0;
            st_r    <= StVel;
          end
        end
        StVel: st_r <= StVelW;
        StVelW: if (ddone) begin
          if (dq > 64'h7FFF_FFFF) begin
            meas_r <= 31'h7FFF_FFFF; sat_r <= 1'b1;
          end else begin
            meas_r <= dq[30:0];
          end
          st_r <= StAcc;
        end
        StAcc: begin
          // error clip; the rate dividend is prepared in StMul
          if (err_w > Max32) begin
            err_r <= 32'sh7FFF_FFFF; sat_r <= 1'b1;
          end else if (err_w < Min32) begin
            err_r <= 32'sh8000_0000; sat_r <= 1'b1;
          end else begin
            err_r <= err_w[31:0];
          end
          st_r <= StMul;
        end
        StMul: begin
          prod_r <= diff_w;
          neg_r  <= diff_w[63];
          st_r   <= StErr;
        end
        StErr: st_r <= StRateW;
        StRateW: if (ddone) begin
          if (qs_w > Max32) begin
            rate_r <= 32'sh7FFF_FFFF; sat_r <= 1'b1;
          end else if (qs_w < Min32) begin
            rate_r <= 32'sh8000_0000; sat_r <= 1'b1;
          end else begin
            rate_r <= qs_w[31:0];
          end
          perr_r <= err_r;
          // accumulators
          if (esum_w > 49'(Max48)) begin
            esum_r <= Max48; sat_r <= 1'b1;
          end else if (esum_w < 49'(Min48)) begin
            esum_r <= Min48; sat_r <= 1'b1;
          end else begin
            esum_r <= esum_w[47:0];
          end
          if (tsum_w[48]) begin
            tsum_r <= '1; sat_r <= 1'b1;
          end else begin
            tsum_r <= tsum_w[47:0];
          end
          st_r <= StSum;
        end
        StSum: begin
          prod_r <= 64'(esum_r) * 64'(signed'({1'b0, ki_r}));
          neg_r  <= esum_r[47] && (ki_r != '0);
          st_r   <= StIntM;
        end
        StIntM: st_r <= StIntW;
        StIntW: if (ddone) begin
          if (qs_w > Max32) begin
            integ_r <= 32'sh7FFF_FFFF; sat_r <= 1'b1;
          end else if (qs_w < Min32) begin
            integ_r <= 32'sh8000_0000; sat_r <= 1'b1;
          end else begin
            integ_r <= qs_w[31:0];
          end
          prod_r <= 64'(rate_r) * 64'(signed'({1'b0, kd_r}));
          neg_r  <= 1'b0;
          st_r   <= StOut;
        end
        StOut: begin
          if (neg_r) begin
            // second step: clip the scaled total once the output is free
            if (!o_valid_r) begin
              neg_r <= 1'b0;
              if (total_r > Max32) begin
                o_ctl_r <= 32'sh7FFF_FFFF; o_sat_r <= 1'b1;
              end else if (total_r < Min32) begin
                o_ctl_r <= 32'sh8000_0000; o_sat_r <= 1'b1;
              end else begin
                o_ctl_r <= total_r[31:0]; o_sat_r <= sat_r;
              end
              o_meas_r  <= meas_r;
              o_valid_r <= 1'b1;
              st_r      <= StIdle;
            end
          end else begin
            total_r <= 64'(signed'(sum_w[47:0])) * 64'(signed'({1'b0, kp_r}));
            neg_r   <= 1'b1;
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid             = o_valid_r;
  assign out_measured_velocity = o_meas_r;
  assign out_control_value     = o_ctl_r;
  assign out_saturated         = o_sat_r;

endmodule
